[design/mie_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mie_pkg: shared types and constants for the modular inverse block
// Operand width, result status codes, controller states and the command
// and status bundles exchanged between controller and datapath.
// ----------------------------------------------------------------------------
package mie_pkg;

  localparam int W     = 63;             // operand width
  localparam int CNT_W = $clog2(W);      // divider step counter width

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_GCD   = 2'd1,
    ST_MZERO = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ZCHK,
    S_RED_WAIT,
    S_LOOP,
    S_STEP_WAIT,
    S_NORM_WAIT,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FIN_ZERO,
    OP_RED_START,
    OP_RED_UPD,
    OP_STEP_START,
    OP_STEP_UPD,
    OP_NORM_START,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic m_zero;
    logic r1_zero;
    logic div_done;
  } stat_t;

endpackage

[design/modular_inverse_ext_euclid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid: modular inverse by extended Euclid
// Reduces the value modulo the modulus, runs the extended Euclidean
// algorithm and returns the normalized Bezout coefficient with a status.
// ----------------------------------------------------------------------------
//  Channel   Ports                              Transfer
//  input     in_value, in_modulus               start high while busy low
//  result    out_inverse_out, out_status        out_valid high, one cycle
//
//  Every division (reduction, each Euclid step, normalization) runs through
//  one shared radix-2 divider, so the block takes one item at a time. A
//  zero modulus skips the divider and gives status ST_MZERO. Reset is
//  synchronous and returns the controller to idle. The receiver cannot
//  stall; busy stays high until the strobe.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [mie_pkg::W-1:0] in_value,
  input  logic [mie_pkg::W-1:0] in_modulus,
  output logic                  out_valid,
  output logic [mie_pkg::W-1:0] out_inverse_out,
  output logic [1:0]            out_status
);
  import mie_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  mie_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_value        (in_value),
    .in_modulus      (in_modulus),
    .out_inverse_out (out_inverse_out),
    .out_status      (out_status)
  );

endmodule

[design/mie_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mie_div: radix-2 restoring divider
// One quotient bit per cycle, most significant first. The quotient bit is
// exposed each cycle; the remainder is final when done pulses.
// ----------------------------------------------------------------------------
module mie_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [mie_pkg::W-1:0] dividend,
  input  logic [mie_pkg::W-1:0] divisor,
  output logic                 qbit_valid,
  output logic                 qbit,
  output logic                 done,
  output logic [mie_pkg::W-1:0] rem
);
  import mie_pkg::*;

  logic [W-1:0]     num_r, den_r, rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [W:0]       trial, diff;
  logic             ge;

  always_comb begin
    trial   = {rem_r, num_r[W-1]};
    diff    = trial - {1'b0, den_r};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
      cnt_r <= CNT_W'(W - 1);
    end else if (busy_r) begin
      num_r <= {num_r[W-2:0], 1'b0};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign qbit_valid = busy_r;
  assign qbit       = ge;
  assign done       = done_r;
  assign rem        = rem_r;

endmodule

[design/mie_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mie_dpath: extended Euclid datapath
// Holds remainders, Bezout coefficients and the running quotient product,
// drives the shared divider and forms the normalized result.
// ----------------------------------------------------------------------------
module mie_dpath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mie_pkg::cmd_t         cmd,
  output mie_pkg::stat_t        stat,
  input  logic [mie_pkg::W-1:0] in_value,
  input  logic [mie_pkg::W-1:0] in_modulus,
  output logic [mie_pkg::W-1:0] out_inverse_out,
  output logic [1:0]            out_status
);
  import mie_pkg::*;

  logic [W-1:0] m_r, r0_r, r1_r;
  logic [W:0]   s0_r, s1_r, prod_r;
  logic [W-1:0] out_inv_r;
  status_t      out_st_r;

  logic         div_start, qbit_valid, qbit, div_done;
  logic [W-1:0] div_a, div_b, div_rem, mag;
  logic [W:0]   s0_neg, t_val;

  assign s0_neg = ~s0_r + 1'b1;
  assign mag    = s0_r[W] ? s0_neg[W-1:0] : s0_r[W-1:0];
  assign t_val  = s0_r - prod_r;

  always_comb begin
    div_start = 1'b0;
    div_a     = r0_r;
    div_b     = r1_r;
    unique case (cmd.op)
      OP_RED_START: begin
        div_start = 1'b1;
        div_a     = r1_r;
        div_b     = m_r;
      end
      OP_STEP_START: begin
        div_start = 1'b1;
      end
      OP_NORM_START: begin
        div_start = 1'b1;
        div_a     = mag;
        div_b     = m_r;
      end
      default: ;
    endcase
  end

  mie_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (div_start),
    .dividend   (div_a),
    .divisor    (div_b),
    .qbit_valid (qbit_valid),
    .qbit       (qbit),
    .done       (div_done),
    .rem        (div_rem)
  );

  // Quotient times s1, built from the quotient bits as they arrive.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_STEP_START) begin
      prod_r <= '0;
    end else if (qbit_valid) begin
      prod_r <= {prod_r[W-1:0], 1'b0} + (qbit ? s1_r : '0);
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        m_r  <= in_modulus;
        r1_r <= in_value;
      end
      OP_RED_UPD: begin
        r0_r <= m_r;
        r1_r <= div_rem;
        s0_r <= '0;
        s1_r <= (W+1)'(1);
      end
      OP_STEP_UPD: begin
        s0_r <= s1_r;
        s1_r <= t_val;
        r0_r <= r1_r;
        r1_r <= div_rem;
      end
      OP_FIN_ZERO: begin
        out_inv_r <= '0;
        out_st_r  <= ST_MZERO;
      end
      OP_FINISH: begin
        out_inv_r <= (s0_r[W] && div_rem != '0) ? m_r - div_rem : div_rem;
        out_st_r  <= (r0_r == W'(1)) ? ST_OK : ST_GCD;
      end
      default: ;
    endcase
  end

  assign stat.m_zero   = (m_r == '0);
  assign stat.r1_zero  = (r1_r == '0);
  assign stat.div_done = div_done;

  assign out_inverse_out = out_inv_r;
  assign out_status      = out_st_r;

endmodule

[design/mie_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mie_ctrl: sequencing state machine
// Steps through load, reduction, the Euclid loop and normalization (or goes
// straight to done on a zero modulus), and issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module mie_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output logic           out_valid,
  output mie_pkg::cmd_t  cmd,
  input  mie_pkg::stat_t stat
);
  import mie_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (start) state_nxt = S_ZCHK;
      S_ZCHK:      state_nxt = stat.m_zero ? S_DONE : S_RED_WAIT;
      S_RED_WAIT:  if (stat.div_done) state_nxt = S_LOOP;
      S_LOOP:      state_nxt = stat.r1_zero ? S_NORM_WAIT : S_STEP_WAIT;
      S_STEP_WAIT: if (stat.div_done) state_nxt = S_LOOP;
      S_NORM_WAIT: if (stat.div_done) state_nxt = S_DONE;
      S_DONE:      state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    unique case (state_r)
      S_IDLE:      if (start) cmd.op = OP_LOAD;
      S_ZCHK:      cmd.op = stat.m_zero ? OP_FIN_ZERO : OP_RED_START;
      S_RED_WAIT:  if (stat.div_done) cmd.op = OP_RED_UPD;
      S_LOOP:      cmd.op = stat.r1_zero ? OP_NORM_START : OP_STEP_START;
      S_STEP_WAIT: if (stat.div_done) cmd.op = OP_STEP_UPD;
      S_NORM_WAIT: if (stat.div_done) cmd.op = OP_FINISH;
      default:     cmd.op = OP_NONE;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for modular_inverse_ext_euclid
// Sends value/modulus pairs through the start/busy command port, predicts
// each inverse and status with a 64-bit extended Euclid model, and checks
// every strobed result in order against the oldest pending prediction.
// ----------------------------------------------------------------------------
module testbench;
  import mie_pkg::*;

  localparam int          QUIET_LIMIT  = 40000;  // cycles with no transfer at all
  localparam int          RANDOM_ITEMS = 80;
  localparam int          MAX_REPORTS  = 10;
  localparam logic [W-1:0] ALL_ONES    = {W{1'b1}};
  localparam logic [W-1:0] FIB_91      = 63'd4660046610375530309;
  localparam logic [W-1:0] FIB_92      = 63'd7540113804746346429;

  typedef struct packed {
    logic [W-1:0] inverse;
    status_t      status;
  } inverse_result_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         start      = 1'b0;
  logic [W-1:0] in_value   = '0;
  logic [W-1:0] in_modulus = '0;
  logic         busy;
  logic         out_valid;
  logic [W-1:0] out_inverse_out;
  logic [1:0]   out_status;

  inverse_result_t pending_inverses[$];
  inverse_result_t oldest;
  int unsigned     items_sent     = 0;
  int unsigned     results_checked = 0;
  int unsigned     error_count    = 0;
  int unsigned     quiet_cycles   = 0;

  modular_inverse_ext_euclid i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_value        (in_value),
    .in_modulus      (in_modulus),
    .out_valid       (out_valid),
    .out_inverse_out (out_inverse_out),
    .out_status      (out_status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Extended Euclid on (modulus, value mod modulus) in 64-bit two's complement,
  // with the coefficient folded back into 0 .. modulus-1.
  function automatic void predict_inverse(input logic [W-1:0] val, input logic [W-1:0] modv,
                                          output logic [W-1:0] inv, output status_t st);
    bit [63:0] m, r0, r1, s0, s1, q, t, r, mag, coef;
    m = {1'b0, modv};
    if (m == 64'd0) begin
      inv = '0;
      st  = ST_MZERO;
    end else begin
      r0 = m;
      r1 = {1'b0, val} % m;
      s0 = 64'd0;
      s1 = 64'd1;
      while (r1 != 64'd0) begin
        q  = r0 / r1;
        t  = s0 - q * s1;
        r  = r0 % r1;
        s0 = s1;
        s1 = t;
        r0 = r1;
        r1 = r;
      end
      if (s0[63]) begin
        mag  = (64'd0 - s0) % m;
        coef = (mag == 64'd0) ? 64'd0 : m - mag;
      end else begin
        coef = s0 % m;
      end
      inv = coef[W-1:0];
      st  = (r0 == 64'd1) ? ST_OK : ST_GCD;
    end
  endfunction

  function automatic logic [W-1:0] rand_word();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[W-1:0];
  endfunction

  // Start stays high after the transfer; the caller either sends again in the
  // same step or lowers it through pause_sender.
  task automatic send_item(input logic [W-1:0] val, input logic [W-1:0] modv);
    inverse_result_t predicted;
    logic [W-1:0]    inv;
    status_t         st;
    predict_inverse(val, modv, inv, st);
    predicted.inverse = inv;
    predicted.status  = st;
    start      <= 1'b1;
    in_value   <= val;
    in_modulus <= modv;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_inverses.insert(pending_inverses.size(), predicted);
    items_sent++;
  endtask

  task automatic pause_sender(input int unsigned cycles);
    if (cycles != 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_inverses.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("ERROR: unexpected result inverse=%0d status=%0d",
                   out_inverse_out, out_status);
      end else begin
        oldest = pending_inverses.pop_front();
        results_checked++;
        if (out_inverse_out !== oldest.inverse || out_status !== oldest.status) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("ERROR: result %0d expected inverse=%0d status=%0d, got inverse=%0d status=%0d",
                     results_checked, oldest.inverse, oldest.status,
                     out_inverse_out, out_status);
        end
      end
    end
  end

  task automatic test_zero_modulus();
    send_item('0, '0);
    send_item(ALL_ONES, '0);
    send_item(63'd12345, '0);
  endtask

  task automatic test_modulus_one();
    send_item('0, 63'd1);
    send_item(ALL_ONES, 63'd1);
  endtask

  // Values that are whole multiples of the modulus give a zero coefficient.
  task automatic test_multiples();
    send_item(63'd21, 63'd7);
    send_item('0, ALL_ONES);
    send_item(ALL_ONES, ALL_ONES);
    send_item(63'd2000, 63'd1000);
  endtask

  task automatic test_extremes();
    send_item(63'd1, ALL_ONES);
    send_item(ALL_ONES - 63'd1, ALL_ONES);
    send_item(63'd2, ALL_ONES);
    send_item(ALL_ONES, 63'd2);
    send_item(ALL_ONES, ALL_ONES - 63'd1);
    send_item(ALL_ONES, 63'd3);
    send_item(ALL_ONES - 63'd1, {1'b1, {(W-1){1'b0}}});
    send_item(63'd6, 63'd9);
    send_item(63'd3, 63'd7);
    send_item(63'd10, 63'd17);
  endtask

  // Consecutive Fibonacci numbers force the longest chain of Euclid steps.
  task automatic test_longest_chain();
    send_item(FIB_91, FIB_92);
    send_item(FIB_92, FIB_91);
  endtask

  task automatic test_random();
    int unsigned  sent;
    int unsigned  burst;
    int unsigned  mode;
    int unsigned  factor;
    logic [W-1:0] val;
    logic [W-1:0] modv;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 8);
      while (burst != 0 && sent < RANDOM_ITEMS) begin
        mode = $urandom_range(0, 99);
        if (mode < 55) begin
          val  = rand_word();
          modv = rand_word();
        end else if (mode < 70) begin
          val  = rand_word();
          modv = W'($urandom_range(1, 1000));
        end else if (mode < 80) begin
          // Shared factor, so the gcd is not one.
          factor = $urandom_range(2, 64);
          val    = (rand_word() >> 8) * W'(factor);
          modv   = ((rand_word() >> 8) | 63'd1) * W'(factor);
        end else if (mode < 85) begin
          val  = rand_word();
          modv = '0;
        end else if (mode < 90) begin
          val  = rand_word();
          modv = 63'd1;
        end else if (mode < 95) begin
          modv = (rand_word() >> 32) | 63'd1;
          val  = modv * W'($urandom_range(0, 1000));
        end else begin
          val  = $urandom_range(0, 1) ? ALL_ONES : '0;
          modv = rand_word();
        end
        send_item(val, modv);
        sent++;
        burst--;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 20));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_zero_modulus();
    test_modulus_one();
    test_multiples();
    pause_sender(3);
    test_extremes();
    test_longest_chain();
    pause_sender(5);
    test_random();
    pause_sender(1);
    start <= 1'b0;
    while (pending_inverses.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered zero and unit moduli, multiples, full-width extremes, the longest");
    $display("Euclid chain and random operands: %0d items sent, %0d results checked.",
             items_sent, results_checked);
    if (error_count == 0) begin
      $display("modular_inverse_ext_euclid test passed");
    end else begin
      $display("%0d failures", error_count);
      $display("modular_inverse_ext_euclid test failed");
    end
    $finish;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("ERROR: no transfer for %0d cycles", QUIET_LIMIT);
    $display("modular_inverse_ext_euclid test failed");
    $finish;
  end

endmodule
